// File: rtl/core/past_pkg.sv
// ----------------------------------------------------------------------------
// past_pkg
// Shared types, codes and helpers for the pressure adaptive sample throttle.
// ----------------------------------------------------------------------------
package past_pkg;

	// Register map (index = paddr[3:2])
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_CRITICAL = 2'd0;
	localparam logic [1:0] REG_ELEVATED = 2'd1;
	localparam logic [1:0] REG_NORMAL   = 2'd2;

	localparam logic [31:0] CRITICAL_RST = 32'd100;
	localparam logic [31:0] ELEVATED_RST = 32'd500;
	localparam logic [31:0] NORMAL_RST   = 32'd1000;

	// Pressure levels; the unused code falls back to normal
	localparam logic [1:0] PRESS_NORMAL   = 2'd0;
	localparam logic [1:0] PRESS_ELEVATED = 2'd1;
	localparam logic [1:0] PRESS_CRITICAL = 2'd2;

	// Actions
	localparam logic ACT_POLL  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// Result outcomes
	localparam logic [1:0] OUT_SAMPLED   = 2'd0;
	localparam logic [1:0] OUT_THROTTLED = 2'd1;
	localparam logic [1:0] OUT_FAILED    = 2'd2;
	localparam logic [1:0] OUT_CLEARED   = 2'd3;

	// Interval configuration as seen by the datapath
	typedef struct packed {
		logic [31:0] critical;
		logic [31:0] elevated;
		logic [31:0] normal;
		logic        ok;
	} past_cfg_t;

	// Increment that holds at all ones
	function automatic logic [63:0] sat_inc(input logic [63:0] v);
		sat_inc = (&v) ? v : v + 64'd1;
	endfunction

endpackage

// File: rtl/core/past_cfg_regs.sv
// ----------------------------------------------------------------------------
// past_cfg_regs
// APB register file for the three pressure intervals and the validity check.
// ----------------------------------------------------------------------------
module past_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [past_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output past_pkg::past_cfg_t         cfg
);
	import past_pkg::*;

	logic [31:0] critical_q;
	logic [31:0] elevated_q;
	logic [31:0] normal_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	// Write on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			critical_q <= CRITICAL_RST;
			elevated_q <= ELEVATED_RST;
			normal_q   <= NORMAL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CRITICAL: critical_q <= pwdata;
				REG_ELEVATED: elevated_q <= pwdata;
				REG_NORMAL:   normal_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_CRITICAL: prdata = critical_q;
			REG_ELEVATED: prdata = elevated_q;
			REG_NORMAL:   prdata = normal_q;
			default:      prdata = 32'd0;
		endcase
	end

	// Intervals must be nonzero and ordered critical <= elevated <= normal
	assign cfg.critical = critical_q;
	assign cfg.elevated = elevated_q;
	assign cfg.normal   = normal_q;
	assign cfg.ok       = (critical_q != 32'd0) && (critical_q <= elevated_q) &&
	                      (elevated_q <= normal_q);

endmodule

// File: rtl/core/pressure_adaptive_sample_throttle.sv
// ----------------------------------------------------------------------------
// pressure_adaptive_sample_throttle
// Poll throttle whose sampling interval follows the reported pressure level.
// ----------------------------------------------------------------------------
// Path from poll transfer to result valid: the input register, then the
// state/result register. Throughput: one poll per cycle unless the result
// stalls; a stalled result holds the input register, so at most two polls
// wait. The state update for one poll is a single pass of compare, saturating
// add and counter increments. Reset clears all statistics and loads the
// default intervals (100, 500, 1000 ms).
module pressure_adaptive_sample_throttle (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [past_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// poll channel
	input  logic                        poll_valid,
	output logic                        poll_ready,
	input  logic                        action,
	input  logic [63:0]                 time_ms,
	input  logic                        capture_ok,
	input  logic                        apply_ok,
	input  logic [1:0]                  pressure,
	// result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [1:0]                  outcome,
	output logic [63:0]                 poll_total,
	output logic [63:0]                 sample_total,
	output logic [63:0]                 throttle_total,
	output logic [63:0]                 failure_total,
	output logic [63:0]                 due_time,
	output logic [63:0]                 last_sample_time
);
	import past_pkg::*;

	past_cfg_t cfg;

	// input stage
	logic        valid_s1;
	logic        action_s1;
	logic [63:0] time_s1;
	logic        cap_s1;
	logic        app_s1;
	logic [1:0]  press_s1;

	// statistics state; it doubles as the result register
	logic        result_valid_q;
	logic [1:0]  outcome_q;
	logic [63:0] polls_q;
	logic [63:0] samples_q;
	logic [63:0] throttled_q;
	logic [63:0] failures_q;
	logic [63:0] next_due_q;
	logic [63:0] last_attempt_q;
	logic        attempted_q;

	logic [1:0]  outcome_d;
	logic [63:0] polls_d;
	logic [63:0] samples_d;
	logic [63:0] throttled_d;
	logic [63:0] failures_d;
	logic [63:0] next_due_d;
	logic [63:0] last_attempt_d;
	logic        attempted_d;

	logic        advance;
	logic [31:0] interval;
	logic [64:0] due_sum;
	logic [63:0] due_sat;

	past_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance when the result slot is free or being drained
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign poll_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_ready && poll_valid) begin
			action_s1 <= action;
			time_s1   <= time_ms;
			cap_s1    <= capture_ok;
			app_s1    <= apply_ok;
			press_s1  <= pressure;
		end
	end

	// Pick the interval for the reported pressure
	always_comb begin
		unique case (press_s1)
			PRESS_CRITICAL: interval = cfg.critical;
			PRESS_ELEVATED: interval = cfg.elevated;
			default:        interval = cfg.normal;
		endcase
	end

	// Saturating due time
	assign due_sum = {1'b0, time_s1} + {33'd0, interval};
	assign due_sat = due_sum[64] ? '1 : due_sum[63:0];

	// Next statistics for the item in the input stage
	always_comb begin
		outcome_d      = OUT_SAMPLED;
		polls_d        = polls_q;
		samples_d      = samples_q;
		throttled_d    = throttled_q;
		failures_d     = failures_q;
		next_due_d     = next_due_q;
		last_attempt_d = last_attempt_q;
		attempted_d    = attempted_q;
		if (action_s1 == ACT_CLEAR) begin
			outcome_d      = OUT_CLEARED;
			polls_d        = '0;
			samples_d      = '0;
			throttled_d    = '0;
			failures_d     = '0;
			next_due_d     = '0;
			last_attempt_d = '0;
			attempted_d    = 1'b0;
		end else begin
			polls_d = sat_inc(polls_q);
			priority if (!cfg.ok) begin
				failures_d = sat_inc(failures_q);
				outcome_d  = OUT_FAILED;
			end else if (attempted_q && (time_s1 < next_due_q)) begin
				throttled_d = sat_inc(throttled_q);
				outcome_d   = OUT_THROTTLED;
			end else begin
				attempted_d    = 1'b1;
				last_attempt_d = time_s1;
				next_due_d     = due_sat;
				if (!cap_s1) begin
					failures_d = sat_inc(failures_q);
					outcome_d  = OUT_FAILED;
				end else begin
					samples_d = sat_inc(samples_q);
					if (!app_s1) begin
						failures_d = sat_inc(failures_q);
						outcome_d  = OUT_FAILED;
					end
				end
			end
		end
	end

	// Commit state and present the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			polls_q        <= '0;
			samples_q      <= '0;
			throttled_q    <= '0;
			failures_q     <= '0;
			next_due_q     <= '0;
			last_attempt_q <= '0;
			attempted_q    <= 1'b0;
		end else begin
			if (advance) begin
				result_valid_q <= 1'b1;
				polls_q        <= polls_d;
				samples_q      <= samples_d;
				throttled_q    <= throttled_d;
				failures_q     <= failures_d;
				next_due_q     <= next_due_d;
				last_attempt_q <= last_attempt_d;
				attempted_q    <= attempted_d;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_q <= outcome_d;
		end
	end

	assign result_valid     = result_valid_q;
	assign outcome          = outcome_q;
	assign poll_total       = polls_q;
	assign sample_total     = samples_q;
	assign throttle_total   = throttled_q;
	assign failure_total    = failures_q;
	assign due_time         = next_due_q;
	assign last_sample_time = last_attempt_q;

endmodule

// File: rtl/core/past_checker.sv
// ----------------------------------------------------------------------------
// past_checker
// Port-level checks for the pressure adaptive sample throttle.
// ----------------------------------------------------------------------------
module past_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  outcome,
	input logic [63:0] poll_total,
	input logic [63:0] sample_total,
	input logic [63:0] throttle_total,
	input logic [63:0] failure_total,
	input logic [63:0] due_time,
	input logic [63:0] last_sample_time
);
	import past_pkg::*;

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(outcome) &&
		$stable(poll_total))
		else $error("result changed while stalled");

	// Clear zeroes every statistic
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && outcome == OUT_CLEARED |->
		poll_total == 64'd0 && sample_total == 64'd0 && throttle_total == 64'd0 &&
		failure_total == 64'd0 && due_time == 64'd0 && last_sample_time == 64'd0)
		else $error("clear left statistics nonzero");

	// Throttle needs a pending due time
	a_throttle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && outcome == OUT_THROTTLED |->
		throttle_total != 64'd0 && poll_total != 64'd0 && due_time != 64'd0)
		else $error("throttle without due time or count");

	// Sample and failure outcomes are counted
	a_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (outcome == OUT_SAMPLED || outcome == OUT_FAILED) |->
		poll_total != 64'd0 &&
		(outcome == OUT_FAILED || sample_total != 64'd0) &&
		(outcome == OUT_SAMPLED || failure_total != 64'd0))
		else $error("outcome not reflected in counters");

endmodule

bind pressure_adaptive_sample_throttle past_checker u_past_checker (.*);
